// ----- src/vlq_pkg.sv -----
// Shared types for the variable-length quantity encoder.
`default_nettype none

package vlq_pkg;

    localparam int unsigned MAX_BYTES = 5;
    localparam logic [7:0] CONT_BIT   = 8'h80;

    // Byte count of one encoding, 1 to 5.
    typedef logic [2:0] vlq_cnt_t;

    // One classified item: groups least significant first, continuation bits set on all but group 0.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] grp;
        vlq_cnt_t                  cnt;
    } vlq_item_t;

    // Queue status seen by the input handshake and the back end.
    typedef struct packed {
        logic empty;
        logic full;
    } vlq_qstat_t;

endpackage

`default_nettype wire

// ----- src/vlq_front.sv -----
// Front end: splits a word into groups of up to 7 bits and sizes the encoding.
`default_nettype none

module vlq_front (
    input  wire logic              op,
    input  wire logic [31:0]       value,
    output vlq_pkg::vlq_item_t     item
);

    logic        neg;
    logic [31:0] mag;
    logic [25:0] rest;
    logic [7:0]  g0;

    always_comb
    begin
        neg  = op & value[31];
        mag  = neg ? (~value + 32'd1) : value;
        rest = op ? mag[31:6] : {1'b0, value[31:7]};
        g0   = op ? {1'b0, neg, mag[5:0]} : {1'b0, value[6:0]};

        item.grp[0] = g0;
        item.grp[1] = vlq_pkg::CONT_BIT | {1'b0, rest[6:0]};
        item.grp[2] = vlq_pkg::CONT_BIT | {1'b0, rest[13:7]};
        item.grp[3] = vlq_pkg::CONT_BIT | {1'b0, rest[20:14]};
        item.grp[4] = vlq_pkg::CONT_BIT | {3'b000, rest[25:21]};

        priority if (rest[25:21] != 5'd0)
            item.cnt = 3'd5;
        else if (rest[20:14] != 7'd0)
            item.cnt = 3'd4;
        else if (rest[13:7] != 7'd0)
            item.cnt = 3'd3;
        else if (rest[6:0] != 7'd0)
            item.cnt = 3'd2;
        else
            item.cnt = 3'd1;
    end

endmodule

`default_nettype wire

// ----- src/vlq_queue.sv -----
// Short FIFO of classified items between front and back ends.
`default_nettype none

module vlq_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire vlq_pkg::vlq_item_t wr_item,
    input  wire logic               pop,
    output vlq_pkg::vlq_item_t      head,
    output vlq_pkg::vlq_qstat_t     stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    vlq_pkg::vlq_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        stat.empty = (count_reg == CNT_W'(0));
        stat.full  = (count_reg == CNT_W'(DEPTH));
        head       = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0)
                                                           : wr_ptr_reg + PTR_W'(1);
        rd_ptr_next = rd_ptr_reg;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0)
                                                           : rd_ptr_reg + PTR_W'(1);
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count over depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push lost");
`endif

endmodule

`default_nettype wire

// ----- src/vlq_back.sv -----
// Back end: emits queued groups, most significant first, a byte per cycle unless stalled.
`default_nettype none

module vlq_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire vlq_pkg::vlq_item_t  head,
    input  wire vlq_pkg::vlq_qstat_t qstat,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [7:0]               code_byte,
    output logic                     last
);

    logic              act_reg, act_next;
    vlq_pkg::vlq_cnt_t pos_reg, pos_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        code_byte_reg, code_byte_next;
    logic              last_reg, last_next;

    logic              advance;
    vlq_pkg::vlq_cnt_t sel;
    logic [7:0]        sel_byte;

    always_comb
    begin
        advance = !qstat.empty && (!out_valid_reg || out_ready);
        sel     = act_reg ? pos_reg : head.cnt - 3'd1;

        unique case (sel)
            3'd0:    sel_byte = head.grp[0];
            3'd1:    sel_byte = head.grp[1];
            3'd2:    sel_byte = head.grp[2];
            3'd3:    sel_byte = head.grp[3];
            3'd4:    sel_byte = head.grp[4];
            default: sel_byte = 8'h00;
        endcase

        pop            = advance && (sel == 3'd0);
        act_next       = act_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        code_byte_next = code_byte_reg;
        last_next      = last_reg;

        if (advance)
        begin
            act_next       = (sel != 3'd0);
            pos_next       = sel - 3'd1;
            out_valid_next = 1'b1;
            code_byte_next = sel_byte;
            last_next      = (sel == 3'd0);
        end
        else if (out_ready)
            out_valid_next = 1'b0;

        out_valid = out_valid_reg;
        code_byte = code_byte_reg;
        last      = last_reg;
    end

    always_ff @(posedge clk)
    begin
        code_byte_reg <= code_byte_next;
        last_reg      <= last_next;
        pos_reg       <= pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_reg       <= act_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_cont_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (code_byte_reg[7] != last_reg))
        else $error("continuation bit disagrees with last");

    a_active_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        act_reg |-> !qstat.empty)
        else $error("mid-item with empty queue");
`endif

endmodule

`default_nettype wire

// ----- src/vlq_encoder.sv -----
// Top level of the variable-length quantity encoder.
//
//  channel | signals                      | dir | transaction
//  --------+------------------------------+-----+-------------------------------
//  in      | in_valid in_ready op value   | in  | one 32-bit word to encode
//  out     | out_valid out_ready code_byte| out | one encoded byte, last on final
//          | last                         |     |
//
// A word of n bytes (1 to 5) occupies the byte serializer until all n are
// sent; the serializer's one-byte-per-cycle output, when out_ready does not
// stall it, sets the sustained rate. An accepted word is written into the
// queue and then loaded into the output register as its first byte.
// rst_n is asynchronous and active low; it empties the queue and drops out_valid.
// out_ready low holds the output register; the queue keeps taking words until
// it is full, then in_ready drops.
`default_nettype none

module vlq_encoder #(
    parameter int unsigned QUEUE_DEPTH = 2   // items buffered, 2 or more
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [31:0] value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       code_byte,
    output logic             last
);

    vlq_pkg::vlq_item_t  front_item;
    vlq_pkg::vlq_item_t  head_item;
    vlq_pkg::vlq_qstat_t qstat;
    logic                push;
    logic                pop;

    // Front end classifies the word in the accepting cycle.
    vlq_front u_front (
        .op    (op),
        .value (value),
        .item  (front_item)
    );

    assign in_ready = !qstat.full;
    assign push     = in_valid && !qstat.full;

    vlq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (front_item),
        .pop     (pop),
        .head    (head_item),
        .stat    (qstat)
    );

    // Back end walks the head item from its top group down.
    vlq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_item),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .code_byte (code_byte),
        .last      (last)
    );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the variable-length quantity encoder.
`timescale 1ns / 1ps
`default_nettype none

module tb;

    // Selector codes on the op port
    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    // Group masks and flags of the byte format
    localparam logic [31:0] GROUP7_MASK = 32'h7F;
    localparam logic [31:0] GROUP6_MASK = 32'h3F;
    localparam logic [7:0]  SIGN_FLAG   = 8'h40;

    localparam int unsigned RANDOM_WORDS = 250;
    localparam int unsigned IDLE_LIMIT   = 2000;  // cycles with no transaction on either side
    localparam int unsigned TAIL_CYCLES  = 10;    // settle time after the last byte

    // One queued stimulus entry; hold entries make the driver wait for all bytes
    typedef struct {
        logic        sgn;
        logic [31:0] word;
        logic        hold;
    } word_req_t;

    // One predicted output byte
    typedef struct {
        logic [7:0] code;
        logic       fin;
    } enc_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = OP_UNSIGNED;
    logic [31:0] value = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  code_byte;
    logic        last;

    word_req_t   words_to_send[$];
    enc_byte_t   enc_bytes_due[$];
    int unsigned mismatches = 0;

    vlq_encoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .code_byte (code_byte),
        .last      (last)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: splits one word into its groups and queues the bytes,
    // most significant group first. Signed mode works on the magnitude;
    // 0x80000000 negates to itself, which read as unsigned is 2^31.
    // ------------------------------------------------------------------
    task automatic encode_word(input logic sgn, input logic [31:0] word);
        logic [7:0]  grp [0:vlq_pkg::MAX_BYTES-1];
        logic [31:0] mag;
        logic [31:0] rest;
        logic        neg;
        int          n;
        int          k;
        enc_byte_t   eb;
        if (sgn == OP_SIGNED)
        begin
            neg = word[31];
            mag = neg ? (32'd0 - word) : word;
            grp[0] = 8'(mag & GROUP6_MASK) | (neg ? SIGN_FLAG : 8'h00);
            rest = mag >> 6;
        end
        else
        begin
            grp[0] = 8'(word & GROUP7_MASK);
            rest = word >> 7;
        end
        n = 1;
        while (rest != 32'd0 && n < vlq_pkg::MAX_BYTES)
        begin
            grp[n] = 8'(rest & GROUP7_MASK) | vlq_pkg::CONT_BIT;
            rest = rest >> 7;
            n++;
        end
        for (k = n - 1; k >= 0; k--)
        begin
            eb.code = grp[k];
            eb.fin  = (k == 0);
            enc_bytes_due.push_back(eb);
        end
    endtask

    task automatic add_word(input logic sgn, input logic [31:0] word);
        word_req_t r;
        r.sgn  = sgn;
        r.word = word;
        r.hold = 1'b0;
        words_to_send.push_back(r);
    endtask

    task automatic add_hold();
        word_req_t r;
        r.sgn  = OP_UNSIGNED;
        r.word = 32'd0;
        r.hold = 1'b1;
        words_to_send.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps. A gap of
    // zero keeps back-to-back traffic going. Valid and payload stay put
    // until the transaction completes; each signal gets one update per edge.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic        fire;
        logic        nv;
        logic        n_op;
        logic [31:0] n_val;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op       <= OP_UNSIGNED;
            value    <= 32'd0;
        end
        else
        begin
            fire  = in_valid && in_ready;
            nv    = 1'b0;
            n_op  = op;
            n_val = value;
            if (fire)
            begin
                encode_word(op, value);
                void'(words_to_send.pop_front());
            end
            // Only pick a new entry once the current one is gone
            if (!(in_valid && !fire))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (words_to_send.size() > 0)
                begin
                    if (words_to_send[0].hold)
                    begin
                        // Pause until every predicted byte has come out
                        if (enc_bytes_due.size() == 0)
                            void'(words_to_send.pop_front());
                    end
                    else
                    begin
                        nv    = 1'b1;
                        n_op  = words_to_send[0].sgn;
                        n_val = words_to_send[0].word;
                        if (burst_left > 0)
                            burst_left--;
                        if (burst_left == 0)
                        begin
                            burst_left = $urandom_range(1, 16);
                            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                        end
                    end
                end
                in_valid <= nv;
                op       <= n_op;
                value    <= n_val;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: drives out_ready from a rotating stall pattern that is
    // redrawn each time pat_age wraps (no stalls, random, mostly stalled,
    // long stall) and checks each output transaction against the oldest
    // predicted byte.
    // ------------------------------------------------------------------
    logic [15:0] stall_pat = 16'hFFFF;
    int unsigned pat_age   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic [15:0] n_pat;
        enc_byte_t   eb;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (enc_bytes_due.size() == 0)
                begin
                    $error("code_byte: none expected, got 0x%02h (last %0b)", code_byte, last);
                    mismatches++;
                end
                else
                begin
                    eb = enc_bytes_due.pop_front();
                    if (code_byte !== eb.code)
                    begin
                        $error("code_byte: expected 0x%02h, got 0x%02h", eb.code, code_byte);
                        mismatches++;
                    end
                    if (last !== eb.fin)
                    begin
                        $error("last: expected %0b, got %0b", eb.fin, last);
                        mismatches++;
                    end
                end
            end
            n_pat = {stall_pat[0], stall_pat[15:1]};
            if (pat_age == 47)
            begin
                pat_age = 0;
                case ($urandom_range(0, 3))
                    0: n_pat = 16'hFFFF;
                    1: n_pat = 16'($urandom());
                    2: n_pat = 16'h0001;
                    default: n_pat = 16'hFF00;
                endcase
                if (n_pat == 16'h0000)
                    n_pat = 16'h8001;
            end
            else
            begin
                pat_age++;
            end
            out_ready <= stall_pat[0];
            stall_pat <= n_pat;
        end
    end

    // Watchdog: too long with no transaction on either channel ends the run
    int unsigned idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned i;
        int unsigned w;
        logic        s;
        logic [31:0] v;

        // Directed: zero, group boundaries, widest words, most negative value
        add_word(OP_UNSIGNED, 32'h0000_0000);
        add_word(OP_SIGNED,   32'h0000_0000);
        add_word(OP_UNSIGNED, 32'h0000_003F);
        add_word(OP_SIGNED,   32'h0000_003F);
        add_word(OP_UNSIGNED, 32'h0000_0040);
        add_word(OP_SIGNED,   32'h0000_0040);
        add_word(OP_UNSIGNED, 32'h0000_007F);
        add_word(OP_SIGNED,   32'h0000_007F);
        add_word(OP_UNSIGNED, 32'h0000_0080);
        add_word(OP_SIGNED,   32'h0000_0080);
        add_word(OP_UNSIGNED, 32'h0000_1FFF);
        add_word(OP_SIGNED,   32'h0000_1FFF);
        add_word(OP_UNSIGNED, 32'h0000_2000);
        add_word(OP_SIGNED,   32'h0000_2000);
        add_word(OP_UNSIGNED, 32'h0FFF_FFFF);
        add_word(OP_UNSIGNED, 32'h1000_0000);
        add_word(OP_UNSIGNED, 32'hFFFF_FFFF);
        add_word(OP_SIGNED,   32'hFFFF_FFFF);   // -1
        add_word(OP_SIGNED,   32'hFFFF_FFC0);   // -64, first two-byte negative
        add_word(OP_SIGNED,   32'hFFFF_FFC1);   // -63
        add_word(OP_UNSIGNED, 32'h8000_0000);
        add_word(OP_SIGNED,   32'h8000_0000);   // most negative, magnitude 2^31
        add_word(OP_UNSIGNED, 32'h7FFF_FFFF);
        add_word(OP_SIGNED,   32'h7FFF_FFFF);
        add_hold();

        // Random: mostly width-shaped words so every byte count shows up
        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            s = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: v = $urandom();
                3:
                begin
                    w = $urandom_range(0, 31);
                    v = (32'd1 << w) - 32'($urandom_range(0, 1));
                end
                default:
                begin
                    w = $urandom_range(0, 32);
                    v = (w == 0) ? 32'd0 : ($urandom() >> (32 - w));
                end
            endcase
            if (s == OP_SIGNED && $urandom_range(0, 1) == 1)
                v = 32'd0 - v;
            add_word(s, v);
            if (i == 80 || i == 170)
                add_hold();
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (words_to_send.size() != 0 || in_valid)
            @(posedge clk);
        while (enc_bytes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
